### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int TAB_STOP    = 8;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [15:0] BLANK_RESET = 16'h0F20;
  localparam logic [3:0]  FG_RESET    = 4'hF;
  localparam logic [3:0]  BG_RESET    = 4'h0;

  // register index, taken from paddr[2]
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_line;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_t;

endpackage

### rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// Text console: cell store in RAM, cursor, put-char / clear / read-cell / cursor report.
// Sequence: plain put-char or cursor report registers its result from the accept,
//   cell read goes via S_READ, clear via S_FILL, put-char with scroll via S_COPY then S_FILL.
// One item at a time; scroll and clear sweep the RAM one cell per cycle
//   through a single address counter and the single write port.
// Reset: cursor home, colours 0/15, then a pass over every cell writes
//   0x0F20 to each one; req_ready stays low during the pass.
// ----------------------------------------------------------------------------
module text_console_char_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  tcw_pkg::in_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output tcw_pkg::out_t rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int MOVE   = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_X  = COL_W + 1;
  localparam int ROW_X  = ROW_W + 1;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(MOVE - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;

  logic [2:0]        state;
  logic [ADDR_W-1:0] ptr;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_addr;
  logic [15:0]       fill_data;
  logic              rd_ok;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [3:0]        fg, bg;

  logic              accept;
  logic              put_wr;
  logic              put_scroll;
  logic [ADDR_W-1:0] cur_pos;
  logic [ADDR_W-1:0] next_pos;
  logic [COL_W-1:0]  step_col;
  logic [ROW_W-1:0]  step_row;
  logic [ADDR_W-1:0] step_pos;
  logic              rsp_set;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign pready    = 1'b1;

  assign cur_pos  = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);
  assign next_pos = ADDR_W'(cur_row_next) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_next);

  // put-char cursor update
  always_comb begin
    logic [COL_X-1:0] col_x;
    logic [ROW_X-1:0] row_x;
    col_x  = {1'b0, cur_col};
    row_x  = {1'b0, cur_row};
    put_wr = 1'b0;
    case (req.char_code)
      CH_BS: begin
        if (cur_col != '0) begin
          col_x = col_x - COL_X'(1);
        end
      end
      CH_TAB: begin
        col_x = (col_x + COL_X'(TAB_STOP)) & ~COL_X'(TAB_STOP - 1);
      end
      CH_CR: begin
        col_x = '0;
      end
      CH_LF: begin
        col_x = '0;
        row_x = row_x + ROW_X'(1);
      end
      default: begin
        if (req.char_code inside {[CH_SPACE:CH_DEL]}) begin
          put_wr = 1'b1;
          col_x  = col_x + COL_X'(1);
        end
      end
    endcase
    if (col_x >= COL_X'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + ROW_X'(1);
    end
    put_scroll   = row_x >= ROW_X'(ROWS);
    cur_row_next = put_scroll ? ROW_W'(ROWS - 1) : row_x[ROW_W-1:0];
    cur_col_next = col_x[COL_W-1:0];
  end

  // cursor after the beat, by function
  always_comb begin
    case (req.func)
      FUNC_PUT: begin
        step_col = cur_col_next;
        step_row = cur_row_next;
        step_pos = next_pos;
      end
      FUNC_CLEAR: begin
        step_col = '0;
        step_row = '0;
        step_pos = '0;
      end
      default: begin
        step_col = cur_col;
        step_row = cur_row;
        step_pos = cur_pos;
      end
    endcase
  end

  // result beat ready to show at the next edge
  assign rsp_set = (accept && (req.func == FUNC_PUT) && !put_scroll)
                || (accept && !(req.func inside {FUNC_PUT, FUNC_CLEAR, FUNC_READ}))
                || (state == S_READ)
                || (state == S_FILL && !copy_pend && ptr == LAST_CELL);

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = fill_data;
    if (copy_pend) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr;
      ram_wdata = ram_rdata;
    end else if (state == S_FILL || state == S_INIT) begin
      ram_we    = 1'b1;
    end else if (accept && req.func == FUNC_PUT && put_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cur_pos;
      ram_wdata = {bg, fg, req.char_code};
    end
  end

  assign ram_raddr = (state == S_COPY) ? ptr + ADDR_W'(COLUMNS)
                                       : ADDR_W'(req.cell_index);

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_set) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ptr       <= '0;
      copy_pend <= 1'b0;
      fill_data <= BLANK_RESET;
      cur_col   <= '0;
      cur_row   <= '0;
    end else begin
      case (state)
        S_INIT: begin
          if (ptr == LAST_CELL) begin
            state <= S_IDLE;
          end else begin
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            fill_data         <= {bg, fg, CH_SPACE};
            ptr               <= '0;
            cur_col           <= step_col;
            cur_row           <= step_row;
            rsp.cell_data     <= '0;
            rsp.scrolled      <= (req.func == FUNC_PUT) && put_scroll;
            rsp.cursor_pos    <= 11'(step_pos);
            rsp.cursor_column <= 7'(step_col);
            rsp.cursor_line   <= 5'(step_row);
            case (req.func)
              FUNC_PUT: begin
                if (put_scroll) begin
                  state <= S_COPY;
                end
              end
              FUNC_CLEAR: begin
                state <= S_FILL;
              end
              FUNC_READ: begin
                rd_ok <= 32'(req.cell_index) < CELLS;
                state <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          rsp.cell_data <= rd_ok ? ram_rdata : '0;
          state         <= S_IDLE;
        end
        S_COPY: begin
          // read one row ahead, write the beat back next cycle
          copy_pend <= 1'b1;
          copy_addr <= ptr;
          ptr       <= ptr + ADDR_W'(1);
          if (ptr == LAST_MOVE) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          copy_pend <= 1'b0;
          // hold the pointer while the last copied cell drains
          if (!copy_pend) begin
            if (ptr == LAST_CELL) begin
              state <= S_IDLE;
            end else begin
              ptr <= ptr + ADDR_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_FG:  fg <= pwdata[3:0];
        REG_BG:  bg <= pwdata[3:0];
        default: fg <= fg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FG:  prdata = {28'b0, fg};
      REG_BG:  prdata = {28'b0, bg};
      default: prdata = '0;
    endcase
  end

endmodule

### rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tcw_pkg::out_t rsp
);

  import tcw_pkg::*;

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp.cursor_column) < COLUMNS) && (32'(rsp.cursor_line) < ROWS))
    else $error("cursor off screen");

  // scroll leaves the cursor at the start of the bottom row
  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.scrolled |->
      rsp.cursor_column == '0 && rsp.cursor_line == 5'(ROWS - 1))
    else $error("scroll left cursor misplaced");

  // clearing pass follows reset: no beat taken or shown
  a_reset_pass: assert property (@(posedge clk)
    $past(rst) |-> !req_ready && !rsp_valid)
    else $error("ready or valid right after reset");

endmodule

bind text_console_char_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
